### src/aeup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeup_pkg
// Types and constants shared by the terminal stream parser modules.
// ----------------------------------------------------------------------------
package aeup_pkg;

   localparam int CP_W  = 21;
   localparam int ARG_W = 16;

   typedef enum logic [2:0] {
      MODE_TEXT   = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_CSI    = 3'd2,
      MODE_OSC    = 3'd3,
      MODE_OSCESC = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_SECOND  = 2'd1,
      ST_SGR_RD  = 2'd2,
      ST_SGR_OUT = 2'd3
   } state_type;

   typedef enum logic [4:0] {
      ACT_CELL    = 5'd0,
      ACT_REPL    = 5'd1,
      ACT_LF      = 5'd2,
      ACT_CR      = 5'd3,
      ACT_BS      = 5'd4,
      ACT_UP      = 5'd5,
      ACT_DOWN    = 5'd6,
      ACT_RIGHT   = 5'd7,
      ACT_LEFT    = 5'd8,
      ACT_POS     = 5'd9,
      ACT_ED      = 5'd10,
      ACT_EL      = 5'd11,
      ACT_SAVE    = 5'd12,
      ACT_RESTORE = 5'd13,
      ACT_RESET   = 5'd14,
      ACT_SGR     = 5'd15,
      ACT_VIS     = 5'd16
   } action_type;

   // byte codes
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_8      = 8'h38;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UB     = 8'h42;
   localparam logic [7:0] CH_UC     = 8'h43;
   localparam logic [7:0] CH_UD     = 8'h44;
   localparam logic [7:0] CH_UH     = 8'h48;
   localparam logic [7:0] CH_UI     = 8'h49;
   localparam logic [7:0] CH_UJ     = 8'h4A;
   localparam logic [7:0] CH_UK     = 8'h4B;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_LC     = 8'h63;
   localparam logic [7:0] CH_LF_F   = 8'h66;
   localparam logic [7:0] CH_LH     = 8'h68;
   localparam logic [7:0] CH_LL     = 8'h6C;
   localparam logic [7:0] CH_LM     = 8'h6D;
   localparam logic [7:0] CH_LS     = 8'h73;
   localparam logic [7:0] CH_LU     = 8'h75;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam int         VIS_PARAM = 25;

   typedef struct packed {
      logic accept;
      logic load_pending;
      logic sgr_read;
      logic sgr_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic out_valid;
      logic two_res;
      logic sgr_start;
      logic sgr_last;
   } dp_status_type;

endpackage
`default_nettype wire

### src/aeup_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeup_ctrl
// Sequencer: takes bytes, drains a second result and walks SGR parameters.
// ----------------------------------------------------------------------------
module aeup_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire aeup_pkg::dp_status_type st,
   output aeup_pkg::ctrl_cmd_type      cmd
);

   aeup_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aeup_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         aeup_pkg::ST_IDLE: begin
            req_stall = !st.out_free;
            if (req_valid && st.out_free) begin
               cmd.accept = 1'b1;
               if (st.sgr_start) begin
                  state_in = aeup_pkg::ST_SGR_RD;
               end else if (st.two_res) begin
                  state_in = aeup_pkg::ST_SECOND;
               end
            end
         end
         aeup_pkg::ST_SECOND: begin
            if (st.out_free) begin
               cmd.load_pending = 1'b1;
               state_in         = aeup_pkg::ST_IDLE;
            end
         end
         aeup_pkg::ST_SGR_RD: begin
            cmd.sgr_read = 1'b1;
            state_in     = aeup_pkg::ST_SGR_OUT;
         end
         aeup_pkg::ST_SGR_OUT: begin
            if (st.out_free) begin
               cmd.sgr_emit = 1'b1;
               state_in     = st.sgr_last ? aeup_pkg::ST_IDLE : aeup_pkg::ST_SGR_RD;
            end
         end
         default: begin
            state_in = aeup_pkg::ST_IDLE;
         end
      endcase
   end

   a_two_res: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && st.two_res) |=> (state_ff == aeup_pkg::ST_SECOND && st.out_valid))
      else $error("second result not queued after broken sequence");

   a_sgr_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && st.sgr_start) |=> (state_ff == aeup_pkg::ST_SGR_RD && !st.out_valid))
      else $error("SGR walk did not start cleanly");

   a_sgr_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.sgr_emit |=> st.out_valid)
      else $error("SGR code not presented");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != aeup_pkg::ST_IDLE) |-> req_stall)
      else $error("byte taken while results outstanding");

endmodule
`default_nettype wire

### src/aeup_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeup_dp
// Parser datapath: UTF-8 and escape state, CSI parameter store, result register.
// ----------------------------------------------------------------------------
module aeup_dp #(
   parameter int MAX_PARAMS = 16,
   parameter int PARAM_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         rsp_stall,
   input  wire aeup_pkg::ctrl_cmd_type       cmd,
   output aeup_pkg::dp_status_type           st,
   output logic                              rsp_valid,
   output logic [4:0]                        rsp_action,
   output logic [aeup_pkg::CP_W-1:0]         rsp_code_point,
   output logic [aeup_pkg::ARG_W-1:0]        rsp_arg_a,
   output logic [aeup_pkg::ARG_W-1:0]        rsp_arg_b,
   output logic                              rsp_last
);

   localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int WW = (PARAM_BITS > aeup_pkg::ARG_W) ? PARAM_BITS : aeup_pkg::ARG_W;
   localparam int CP_W  = aeup_pkg::CP_W;
   localparam int ARG_W = aeup_pkg::ARG_W;
   localparam logic [PARAM_BITS-1:0] PMAX     = '1;
   localparam logic [IW-1:0]         LAST_IDX = IW'(MAX_PARAMS - 1);

   function automatic logic [ARG_W-1:0] to_arg(input logic [PARAM_BITS-1:0] v);
      logic [WW-1:0] w;
      w = WW'(v);
      return w[ARG_W-1:0];
   endfunction

   // parse state
   aeup_pkg::mode_type      mode_ff, mode_in;
   logic [1:0]              left_ff, left_in;
   logic [CP_W-1:0]         partial_ff, partial_in;
   logic [PARAM_BITS-1:0]   acc_ff, acc_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [7:0]              priv_ff, priv_in;
   logic [PARAM_BITS-1:0]   p0_ff, p0_in;
   logic [PARAM_BITS-1:0]   p1_ff, p1_in;

   // parameter store, one write port and one registered read port
   logic [PARAM_BITS-1:0]   param_mem [MAX_PARAMS];
   logic [PARAM_BITS-1:0]   rd_data_ff;
   logic [IW-1:0]           sgr_idx_ff;

   // result register and queued second result
   logic                    rsp_valid_ff;
   logic [4:0]              out_act_ff;
   logic [CP_W-1:0]         out_cp_ff;
   logic [ARG_W-1:0]        out_a_ff;
   logic [ARG_W-1:0]        out_b_ff;
   logic                    out_last_ff;
   logic [4:0]              pend_act_ff;
   logic [CP_W-1:0]         pend_cp_ff;

   // decode
   logic [7:0]              c;
   logic [1:0]              cnt;
   logic                    wr_en;
   logic                    sgr_start;
   logic                    do_fresh;
   logic                    broken;
   logic                    f_has;
   aeup_pkg::action_type    f_act;
   logic [CP_W-1:0]         f_cp;
   aeup_pkg::action_type    r1_act;
   logic [CP_W-1:0]         r1_cp;
   logic [ARG_W-1:0]        r1_a;
   logic [ARG_W-1:0]        r1_b;
   aeup_pkg::action_type    r2_act;
   logic [CP_W-1:0]         r2_cp;
   logic [PARAM_BITS+3:0]   acc_x10;
   logic [PARAM_BITS-1:0]   p0, p1, p0_one, p0_m1, p1_m1;
   logic                    has2;
   logic                    out_free;
   logic                    sgr_last;

   assign c        = req_data_byte;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sgr_last = (sgr_idx_ff == idx_ff);

   // acc*10 + digit as shift-add; saturates below
   assign acc_x10 = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                  + (PARAM_BITS+4)'(c[3:0]);

   // the parameter being collected lives in acc until a separator commits it
   assign p0     = (idx_ff == '0) ? acc_ff : p0_ff;
   assign p1     = (idx_ff == IW'(1)) ? acc_ff : p1_ff;
   assign has2   = (idx_ff != '0);
   assign p0_one = (p0 == '0) ? PARAM_BITS'(1) : p0;
   assign p0_m1  = (p0 == '0) ? '0 : p0 - PARAM_BITS'(1);
   assign p1_m1  = (p1 == '0) ? '0 : p1 - PARAM_BITS'(1);

   always_comb begin
      mode_in    = mode_ff;
      left_in    = left_ff;
      partial_in = partial_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      priv_in    = priv_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      wr_en      = 1'b0;
      sgr_start  = 1'b0;
      do_fresh   = 1'b0;
      broken     = 1'b0;
      cnt        = 2'd0;
      f_has      = 1'b0;
      f_act      = aeup_pkg::ACT_CELL;
      f_cp       = '0;
      r1_act     = aeup_pkg::ACT_CELL;
      r1_cp      = '0;
      r1_a       = '0;
      r1_b       = '0;
      r2_act     = aeup_pkg::ACT_CELL;
      r2_cp      = '0;

      case (mode_ff)
         aeup_pkg::MODE_TEXT: begin
            if (left_ff != 2'd0) begin
               if (c[7:6] == 2'b10) begin
                  partial_in = {partial_ff[CP_W-7:0], c[5:0]};
                  left_in    = left_ff - 2'd1;
                  if (left_ff == 2'd1) begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_CELL;
                     r1_cp  = {partial_ff[CP_W-7:0], c[5:0]};
                  end
               end else begin
                  broken   = 1'b1;
                  left_in  = 2'd0;
                  do_fresh = 1'b1;
               end
            end else begin
               do_fresh = 1'b1;
            end
         end
         aeup_pkg::MODE_ESC: begin
            mode_in = aeup_pkg::MODE_TEXT;
            case (c)
               aeup_pkg::CH_LBRK: begin
                  mode_in = aeup_pkg::MODE_CSI;
                  idx_in  = '0;
                  acc_in  = '0;
                  priv_in = 8'h00;
               end
               aeup_pkg::CH_RBRK: mode_in = aeup_pkg::MODE_OSC;
               aeup_pkg::CH_LC: begin
                  cnt    = 2'd1;
                  r1_act = aeup_pkg::ACT_RESET;
               end
               aeup_pkg::CH_7: begin
                  cnt    = 2'd1;
                  r1_act = aeup_pkg::ACT_SAVE;
               end
               aeup_pkg::CH_8: begin
                  cnt    = 2'd1;
                  r1_act = aeup_pkg::ACT_RESTORE;
               end
               default: ;
            endcase
         end
         aeup_pkg::MODE_CSI: begin
            if (c inside {[aeup_pkg::CH_0:aeup_pkg::CH_9]}) begin
               acc_in = (acc_x10 > (PARAM_BITS+4)'(PMAX)) ? PMAX
                                                         : acc_x10[PARAM_BITS-1:0];
            end else if (c == aeup_pkg::CH_SEMI || c == aeup_pkg::CH_COLON) begin
               // separators past the last slot are dropped
               if (idx_ff != LAST_IDX) begin
                  wr_en  = 1'b1;
                  idx_in = idx_ff + IW'(1);
                  acc_in = '0;
                  if (idx_ff == '0) begin
                     p0_in = acc_ff;
                  end
                  if (idx_ff == IW'(1)) begin
                     p1_in = acc_ff;
                  end
               end
            end else if (c inside {[aeup_pkg::CH_LT:aeup_pkg::CH_QUEST]}) begin
               priv_in = c;
            end else if (c inside {[8'h20:8'h2F]}) begin
               // intermediate: nothing to do
            end else if (c inside {[8'h40:8'h7E]}) begin
               mode_in = aeup_pkg::MODE_TEXT;
               case (c)
                  aeup_pkg::CH_LM: begin
                     wr_en     = 1'b1;
                     sgr_start = 1'b1;
                  end
                  aeup_pkg::CH_UH, aeup_pkg::CH_LF_F: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_POS;
                     r1_a   = to_arg(p0_m1);
                     r1_b   = has2 ? to_arg(p1_m1) : '0;
                  end
                  aeup_pkg::CH_UJ: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_ED;
                     r1_a   = to_arg(p0);
                  end
                  aeup_pkg::CH_UK: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_EL;
                     r1_a   = to_arg(p0);
                  end
                  aeup_pkg::CH_UA: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_UP;
                     r1_a   = to_arg(p0_one);
                  end
                  aeup_pkg::CH_UB: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_DOWN;
                     r1_a   = to_arg(p0_one);
                  end
                  aeup_pkg::CH_UC, aeup_pkg::CH_UI: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_RIGHT;
                     r1_a   = to_arg(p0_one);
                  end
                  aeup_pkg::CH_UD, aeup_pkg::CH_UZ: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_LEFT;
                     r1_a   = to_arg(p0_one);
                  end
                  aeup_pkg::CH_LS: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_SAVE;
                  end
                  aeup_pkg::CH_LU: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_RESTORE;
                  end
                  aeup_pkg::CH_LC: begin
                     cnt    = 2'd1;
                     r1_act = aeup_pkg::ACT_RESET;
                  end
                  aeup_pkg::CH_LH, aeup_pkg::CH_LL: begin
                     if (priv_ff == aeup_pkg::CH_QUEST &&
                         p0 == PARAM_BITS'(aeup_pkg::VIS_PARAM)) begin
                        cnt    = 2'd1;
                        r1_act = aeup_pkg::ACT_VIS;
                        r1_a   = (c == aeup_pkg::CH_LH) ? ARG_W'(1) : '0;
                     end
                  end
                  default: ;
               endcase
            end else begin
               mode_in = aeup_pkg::MODE_TEXT;
            end
         end
         aeup_pkg::MODE_OSC: begin
            if (c == aeup_pkg::CH_BEL) begin
               mode_in = aeup_pkg::MODE_TEXT;
            end else if (c == aeup_pkg::CH_ESC) begin
               mode_in = aeup_pkg::MODE_OSCESC;
            end
         end
         default: begin
            mode_in = aeup_pkg::MODE_TEXT;
         end
      endcase

      // byte handled from scratch, also after a broken UTF-8 sequence
      if (do_fresh) begin
         if (c == aeup_pkg::CH_ESC) begin
            mode_in = aeup_pkg::MODE_ESC;
         end else if (c == aeup_pkg::CH_LF) begin
            f_has = 1'b1;
            f_act = aeup_pkg::ACT_LF;
         end else if (c == aeup_pkg::CH_CR) begin
            f_has = 1'b1;
            f_act = aeup_pkg::ACT_CR;
         end else if (c == aeup_pkg::CH_BS) begin
            f_has = 1'b1;
            f_act = aeup_pkg::ACT_BS;
         end else if (c == aeup_pkg::CH_TAB) begin
            f_has = 1'b1;
            f_cp  = CP_W'(c);
         end else if (c inside {[8'hF0:8'hF4]}) begin
            partial_in = CP_W'(c[2:0]);
            left_in    = 2'd3;
         end else if (c inside {[8'hE0:8'hEF]}) begin
            partial_in = CP_W'(c[3:0]);
            left_in    = 2'd2;
         end else if (c inside {[8'hC2:8'hDF]}) begin
            partial_in = CP_W'(c[4:0]);
            left_in    = 2'd1;
         end else if (c inside {[8'h20:aeup_pkg::CH_DEL]}) begin
            f_has = 1'b1;
            f_cp  = CP_W'(c);
         end else if (c[7]) begin
            f_has = 1'b1;
            f_act = aeup_pkg::ACT_REPL;
         end

         if (broken) begin
            cnt    = f_has ? 2'd2 : 2'd1;
            r1_act = aeup_pkg::ACT_REPL;
            r2_act = f_act;
            r2_cp  = f_cp;
         end else begin
            cnt    = f_has ? 2'd1 : 2'd0;
            r1_act = f_act;
            r1_cp  = f_cp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= aeup_pkg::MODE_TEXT;
         left_ff    <= 2'd0;
         partial_ff <= '0;
         acc_ff     <= '0;
         idx_ff     <= '0;
         priv_ff    <= 8'h00;
      end else if (cmd.accept) begin
         mode_ff    <= mode_in;
         left_ff    <= left_in;
         partial_ff <= partial_in;
         acc_ff     <= acc_in;
         idx_ff     <= idx_in;
         priv_ff    <= priv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         param_mem[idx_ff] <= acc_ff;
      end
      if (cmd.sgr_read) begin
         rd_data_ff <= param_mem[sgr_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sgr_idx_ff <= '0;
      end else if (cmd.accept) begin
         sgr_idx_ff <= '0;
      end else if (cmd.sgr_emit) begin
         sgr_idx_ff <= sgr_idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.accept && cnt != 2'd0) || cmd.load_pending || cmd.sgr_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && cnt != 2'd0) begin
         out_act_ff  <= r1_act;
         out_cp_ff   <= r1_cp;
         out_a_ff    <= r1_a;
         out_b_ff    <= r1_b;
         out_last_ff <= (cnt == 2'd1);
         pend_act_ff <= r2_act;
         pend_cp_ff  <= r2_cp;
      end else if (cmd.load_pending) begin
         out_act_ff  <= pend_act_ff;
         out_cp_ff   <= pend_cp_ff;
         out_a_ff    <= '0;
         out_b_ff    <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.sgr_emit) begin
         out_act_ff  <= aeup_pkg::ACT_SGR;
         out_cp_ff   <= '0;
         out_a_ff    <= to_arg(rd_data_ff);
         out_b_ff    <= '0;
         out_last_ff <= sgr_last;
      end
   end

   assign st = '{out_free:  out_free,
                 out_valid: rsp_valid_ff,
                 two_res:   (cnt == 2'd2),
                 sgr_start: sgr_start,
                 sgr_last:  sgr_last};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = out_act_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_arg_a      = out_a_ff;
   assign rsp_arg_b      = out_b_ff;
   assign rsp_last       = out_last_ff;

endmodule
`default_nettype wire

### src/ansi_escape_utf8_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_escape_utf8_parser
// Terminal byte stream to cursor, erase, SGR and cell actions, with UTF-8.
// ----------------------------------------------------------------------------
// One byte per transfer on req_, actions on rsp_ with rsp_last marking the
// final action of each byte. A byte is taken whenever the result register is
// empty or being emptied, so ordinary text runs at one byte per cycle with the
// result register as the only buffer. A byte that breaks a UTF-8 sequence and
// also yields a result of its own holds the input while the second action goes
// out. An SGR final byte occupies the block until its last code is out: each
// code is read from the parameter RAM through its registered read port before
// it is presented. A stall on rsp_ holds the input as well. The parameter RAM
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module ansi_escape_utf8_parser #(
   parameter int MAX_PARAMS = 16,
   parameter int PARAM_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [4:0]                         rsp_action,
   output logic [aeup_pkg::CP_W-1:0]          rsp_code_point,
   output logic [aeup_pkg::ARG_W-1:0]         rsp_arg_a,
   output logic [aeup_pkg::ARG_W-1:0]         rsp_arg_b,
   output logic                               rsp_last
);

   aeup_pkg::ctrl_cmd_type  cmd;
   aeup_pkg::dp_status_type st;

   aeup_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   aeup_dp #(
      .MAX_PARAMS (MAX_PARAMS),
      .PARAM_BITS (PARAM_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .st             (st),
      .rsp_valid      (rsp_valid),
      .rsp_action     (rsp_action),
      .rsp_code_point (rsp_code_point),
      .rsp_arg_a      (rsp_arg_a),
      .rsp_arg_b      (rsp_arg_b),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

### verif/term_action_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// term_action_checker
// Watches the byte and action channels of the terminal stream parser, keeps
// its own parser state, works out the actions each accepted byte must cause
// and compares every action transfer against the oldest one still owed.
// ----------------------------------------------------------------------------
module term_action_checker
   import aeup_pkg::*;
#(
   parameter int MAX_PARAMS = 16,
   parameter int PARAM_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [4:0]        rsp_action,
   input  logic [CP_W-1:0]   rsp_code_point,
   input  logic [ARG_W-1:0]  rsp_arg_a,
   input  logic [ARG_W-1:0]  rsp_arg_b,
   input  logic              rsp_last,
   output int                fail_count,
   output int                pending,
   output int                bytes_seen,
   output int                actions_seen
);

   localparam longint unsigned PARAM_MAX = (64'd1 << PARAM_BITS) - 1;

   // byte ranges of the stream grammar
   localparam logic [7:0] B_SPACE     = 8'h20;
   localparam logic [7:0] B_INTER_END = 8'h2F;
   localparam logic [7:0] B_FINAL_LO  = 8'h40;
   localparam logic [7:0] B_FINAL_HI  = 8'h7E;
   localparam logic [7:0] B_CONT      = 8'h80;
   localparam logic [7:0] B_LEAD2     = 8'hC2;
   localparam logic [7:0] B_LEAD2_END = 8'hDF;
   localparam logic [7:0] B_LEAD3     = 8'hE0;
   localparam logic [7:0] B_LEAD3_END = 8'hEF;
   localparam logic [7:0] B_LEAD4     = 8'hF0;
   localparam logic [7:0] B_LEAD4_END = 8'hF4;

   typedef struct packed {
      action_type       act;
      logic [CP_W-1:0]  cp;
      logic [ARG_W-1:0] a;
      logic [ARG_W-1:0] b;
      logic             last;
   } action_rec;

   action_rec owed_actions[$];
   action_rec batch[$];

   mode_type              mode;
   logic [1:0]            utf8_left;
   logic [CP_W-1:0]       partial;
   logic [PARAM_BITS-1:0] params [MAX_PARAMS];
   logic [4:0]            pidx;
   logic [7:0]            pmark;

   task automatic report(input string msg);
      if (fail_count < 50)
         $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic emit(input action_type act, input logic [CP_W-1:0] cp,
                       input logic [ARG_W-1:0] a, input logic [ARG_W-1:0] b);
      action_rec r;
      r.act  = act;
      r.cp   = cp;
      r.a    = a;
      r.b    = b;
      r.last = 1'b0;
      batch.push_back(r);
   endtask

   function automatic logic [ARG_W-1:0] floor_one(input logic [PARAM_BITS-1:0] v);
      return (v == '0) ? ARG_W'(1) : ARG_W'(v);
   endfunction

   task automatic fresh_byte(input logic [7:0] c);
      if (c == CH_ESC) begin
         mode = MODE_ESC;
      end else if (c == CH_LF) begin
         emit(ACT_LF, '0, '0, '0);
      end else if (c == CH_CR) begin
         emit(ACT_CR, '0, '0, '0);
      end else if (c == CH_BS) begin
         emit(ACT_BS, '0, '0, '0);
      end else if (c == CH_TAB) begin
         emit(ACT_CELL, CP_W'(c), '0, '0);
      end else if (c >= B_LEAD4 && c <= B_LEAD4_END) begin
         partial   = CP_W'(c[2:0]);
         utf8_left = 2'd3;
      end else if (c >= B_LEAD3 && c <= B_LEAD3_END) begin
         partial   = CP_W'(c[3:0]);
         utf8_left = 2'd2;
      end else if (c >= B_LEAD2 && c <= B_LEAD2_END) begin
         partial   = CP_W'(c[4:0]);
         utf8_left = 2'd1;
      end else if (c >= B_SPACE && c < B_CONT) begin
         emit(ACT_CELL, CP_W'(c), '0, '0);
      end else if (c >= B_CONT) begin
         // stray continuation or a lead that can never be valid
         emit(ACT_REPL, '0, '0, '0);
      end
   endtask

   task automatic run_final(input logic [7:0] fin);
      int n;
      logic [PARAM_BITS-1:0] p1;
      n  = int'(pidx) + 1;
      p1 = (n >= 2) ? params[1] : '0;
      case (fin)
         CH_LM: begin
            for (int i = 0; i < n && i < MAX_PARAMS; i++)
               emit(ACT_SGR, '0, ARG_W'(params[i]), '0);
         end
         CH_UH, CH_LF_F: begin
            emit(ACT_POS, '0, floor_one(params[0]) - 1'b1,
                 (n >= 2) ? floor_one(p1) - 1'b1 : '0);
         end
         CH_UJ: emit(ACT_ED, '0, ARG_W'(params[0]), '0);
         CH_UK: emit(ACT_EL, '0, ARG_W'(params[0]), '0);
         CH_UA: emit(ACT_UP, '0, floor_one(params[0]), '0);
         CH_UB: emit(ACT_DOWN, '0, floor_one(params[0]), '0);
         CH_UC, CH_UI: emit(ACT_RIGHT, '0, floor_one(params[0]), '0);
         CH_UD, CH_UZ: emit(ACT_LEFT, '0, floor_one(params[0]), '0);
         CH_LS: emit(ACT_SAVE, '0, '0, '0);
         CH_LU: emit(ACT_RESTORE, '0, '0, '0);
         CH_LC: emit(ACT_RESET, '0, '0, '0);
         CH_LH, CH_LL: begin
            if (pmark == CH_QUEST && params[0] == PARAM_BITS'(VIS_PARAM))
               emit(ACT_VIS, '0, (fin == CH_LH) ? ARG_W'(1) : ARG_W'(0), '0);
         end
         default: ;
      endcase
   endtask

   task automatic take_byte(input logic [7:0] c);
      longint unsigned v;
      batch = {};
      case (mode)
         MODE_TEXT: begin
            if (utf8_left != 2'd0 && c[7:6] == 2'b10) begin
               partial   = {partial[CP_W-7:0], c[5:0]};
               utf8_left = utf8_left - 2'd1;
               if (utf8_left == 2'd0)
                  emit(ACT_CELL, partial, '0, '0);
            end else begin
               // broken sequence: replacement first, then the byte on its own
               if (utf8_left != 2'd0) begin
                  emit(ACT_REPL, '0, '0, '0);
                  utf8_left = 2'd0;
               end
               fresh_byte(c);
            end
         end
         MODE_ESC: begin
            mode = MODE_TEXT;
            if (c == CH_LBRK) begin
               mode      = MODE_CSI;
               pidx      = '0;
               params[0] = '0;
               pmark     = '0;
            end else if (c == CH_RBRK) begin
               mode = MODE_OSC;
            end else if (c == CH_LC) begin
               emit(ACT_RESET, '0, '0, '0);
            end else if (c == CH_7) begin
               emit(ACT_SAVE, '0, '0, '0);
            end else if (c == CH_8) begin
               emit(ACT_RESTORE, '0, '0, '0);
            end
         end
         MODE_CSI: begin
            if (int'(pidx) >= MAX_PARAMS)
               pidx = 5'(MAX_PARAMS - 1);
            if (c >= CH_0 && c <= CH_9) begin
               v = longint'(params[pidx]) * 10 + longint'(c - CH_0);
               if (v > PARAM_MAX)
                  v = PARAM_MAX;
               params[pidx] = PARAM_BITS'(v);
            end else if (c == CH_SEMI || c == CH_COLON) begin
               // separators past the last slot are dropped
               if (int'(pidx) + 1 < MAX_PARAMS) begin
                  pidx         = pidx + 5'd1;
                  params[pidx] = '0;
               end
            end else if (c >= CH_LT && c <= CH_QUEST) begin
               pmark = c;
            end else if (c >= B_SPACE && c <= B_INTER_END) begin
               // intermediate, no effect
            end else if (c >= B_FINAL_LO && c <= B_FINAL_HI) begin
               run_final(c);
               mode = MODE_TEXT;
            end else begin
               mode = MODE_TEXT;
            end
         end
         MODE_OSC: begin
            if (c == CH_BEL)
               mode = MODE_TEXT;
            else if (c == CH_ESC)
               mode = MODE_OSCESC;
         end
         default: mode = MODE_TEXT;
      endcase
   endtask

   always @(posedge clock) begin
      action_rec want;
      action_rec r;
      if (reset) begin
         mode      = MODE_TEXT;
         utf8_left = '0;
         partial   = '0;
         pidx      = '0;
         pmark     = '0;
         owed_actions = {};
      end else begin
         // results at this edge stem from earlier bytes, so compare first
         if (rsp_valid && !rsp_stall) begin
            actions_seen++;
            if (owed_actions.size() == 0) begin
               report($sformatf("action %0d arrived with nothing owed", rsp_action));
            end else begin
               want = owed_actions.pop_front();
               if (rsp_action !== 5'(want.act))
                  report($sformatf("action: got %0d, expected %s",
                                   rsp_action, want.act.name()));
               if (rsp_code_point !== want.cp)
                  report($sformatf("code_point: got %0h, expected %0h",
                                   rsp_code_point, want.cp));
               if (rsp_arg_a !== want.a)
                  report($sformatf("arg_a of %s: got %0d, expected %0d",
                                   want.act.name(), rsp_arg_a, want.a));
               if (rsp_arg_b !== want.b)
                  report($sformatf("arg_b of %s: got %0d, expected %0d",
                                   want.act.name(), rsp_arg_b, want.b));
               if (rsp_last !== want.last)
                  report($sformatf("last of %s: got %b, expected %b",
                                   want.act.name(), rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            bytes_seen++;
            take_byte(req_data_byte);
            foreach (batch[i]) begin
               r      = batch[i];
               r.last = (i == batch.size() - 1);
               owed_actions.push_back(r);
            end
         end
      end
      pending = owed_actions.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives terminal byte streams into the parser: a short directed burst, then
// randomly built text, UTF-8, control, escape, CSI and OSC sequences mixed
// with noise, under random source gaps and sink stalls. The checker beside
// the parser predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import aeup_pkg::*;

   localparam int RANDOM_BYTES = 160;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_data_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [4:0]       rsp_action;
   logic [CP_W-1:0]  rsp_code_point;
   logic [ARG_W-1:0] rsp_arg_a;
   logic [ARG_W-1:0] rsp_arg_b;
   logic             rsp_last;

   int         fail_count;
   int         pending;
   int         bytes_seen;
   int         actions_seen;
   int         sent;
   logic       quiet;
   logic [7:0] burst[$];

   ansi_escape_utf8_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_code_point (rsp_code_point),
      .rsp_arg_a      (rsp_arg_a),
      .rsp_arg_b      (rsp_arg_b),
      .rsp_last       (rsp_last)
   );

   term_action_checker action_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_code_point (rsp_code_point),
      .rsp_arg_a      (rsp_arg_a),
      .rsp_arg_b      (rsp_arg_b),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending        (pending),
      .bytes_seen     (bytes_seen),
      .actions_seen   (actions_seen)
   );

   always #2 clock = ~clock;

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_burst();
      foreach (burst[i])
         send_byte(burst[i]);
      burst = {};
   endtask

   task automatic drain_actions();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic add_digits(input int count);
      repeat (count)
         burst.push_back(CH_0 + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_char();
      case ($urandom_range(1, 4))
         1: burst.push_back(8'($urandom_range(8'h20, 8'h7F)));
         2: burst.push_back(8'($urandom_range(8'hC2, 8'hDF)));
         3: burst.push_back(8'($urandom_range(8'hE0, 8'hEF)));
         default: burst.push_back(8'($urandom_range(8'hF0, 8'hF4)));
      endcase
      // continuation bytes to complete the lead just pushed
      if (burst[burst.size() - 1] >= 8'hF0)
         repeat (3) burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
      else if (burst[burst.size() - 1] >= 8'hE0)
         repeat (2) burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
      else if (burst[burst.size() - 1] >= 8'hC2)
         burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
   endtask

   function automatic logic [7:0] pick_final(input int k);
      case (k)
         0:  return CH_UA;
         1:  return CH_UB;
         2:  return CH_UC;
         3:  return CH_UD;
         4:  return CH_UH;
         5:  return CH_LF_F;
         6:  return CH_UJ;
         7:  return CH_UK;
         8:  return CH_UI;
         9:  return CH_UZ;
         10: return CH_LS;
         11: return CH_LU;
         12: return CH_LC;
         13: return CH_LM;
         14: return CH_LH;
         15: return CH_LL;
         default: return 8'($urandom_range(8'h40, 8'h7E));
      endcase
   endfunction

   task automatic add_separator();
      burst.push_back($urandom_range(0, 3) == 0 ? CH_COLON : CH_SEMI);
   endtask

   task automatic add_random_sequence();
      int nparm;
      case ($urandom_range(0, 15))
         0, 1, 2: repeat ($urandom_range(1, 6)) add_char();
         3: begin
            case ($urandom_range(0, 5))
               0: burst.push_back(CH_LF);
               1: burst.push_back(CH_CR);
               2: burst.push_back(CH_BS);
               3: burst.push_back(CH_TAB);
               4: burst.push_back(CH_BEL);
               default: burst.push_back(8'($urandom_range(0, 8'h1F)));
            endcase
         end
         4: begin
            burst.push_back(CH_ESC);
            case ($urandom_range(0, 3))
               0: burst.push_back(CH_LC);
               1: burst.push_back(CH_7);
               2: burst.push_back(CH_8);
               default: burst.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         5, 6, 7, 8: begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRK);
            if ($urandom_range(0, 3) == 0)
               burst.push_back(CH_LT + 8'($urandom_range(0, 3)));
            nparm = $urandom_range(0, 4);
            for (int i = 0; i < nparm; i++) begin
               if (i > 0)
                  add_separator();
               add_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 7) == 0)
               burst.push_back(8'($urandom_range(8'h20, 8'h2F)));
            burst.push_back(pick_final($urandom_range(0, 17)));
         end
         9: begin
            // cursor visibility, now and then with a near miss
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRK);
            burst.push_back(CH_QUEST);
            burst.push_back(CH_0 + 8'd2);
            burst.push_back(CH_0 + ($urandom_range(0, 3) == 0 ? 8'd4 : 8'd5));
            burst.push_back($urandom_range(0, 1) ? CH_LH : CH_LL);
         end
         10: begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_RBRK);
            repeat ($urandom_range(0, 6))
               burst.push_back(8'($urandom_range(8'h20, 8'hFF)));
            if ($urandom_range(0, 1)) begin
               burst.push_back(CH_BEL);
            end else begin
               burst.push_back(CH_ESC);
               burst.push_back(8'($urandom_range(0, 255)));
            end
         end
         11: begin
            // lead byte, at times with one continuation, then a byte that is not a continuation
            burst.push_back(8'($urandom_range(8'hC2, 8'hF4)));
            if ($urandom_range(0, 1))
               burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
            burst.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                                 : 8'($urandom_range(8'hC0, 8'hFF)));
         end
         12: begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRK);
            add_digits($urandom_range(0, 2));
            burst.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                                 : 8'($urandom_range(8'h80, 8'hFF)));
         end
         13: repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
         14: begin
            // long SGR, sometimes past the parameter slots
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRK);
            nparm = $urandom_range(10, 19);
            for (int i = 0; i < nparm; i++) begin
               if (i > 0)
                  add_separator();
               add_digits($urandom_range(0, 2));
            end
            burst.push_back(CH_LM);
         end
         default: begin
            // parameters often large enough to saturate
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRK);
            add_digits($urandom_range(5, 8));
            add_separator();
            add_digits($urandom_range(4, 7));
            burst.push_back(pick_final($urandom_range(0, 15)));
         end
      endcase
   endtask

   // result side: random stall before each transfer
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         gap = quiet ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      bit paused;
      int directed;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      quiet         = 1'b0;
      sent          = 0;
      paused        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // controls, extremes, broken and maximal UTF-8, escapes, saturation,
      // empty SGR fields, visibility and an OSC closed by ESC backslash
      burst = '{8'h00, 8'hFF, 8'h41, CH_TAB, CH_DEL, CH_LF, CH_CR, CH_BS, CH_BEL,
                8'hC3, 8'h41, 8'hF4, 8'hBF, 8'hBF, 8'hBF, 8'h80,
                CH_ESC, CH_LC, CH_ESC, CH_7, CH_ESC, CH_8,
                CH_ESC, CH_LBRK, CH_9, CH_9, CH_9, CH_9, CH_9, CH_SEMI, CH_SEMI, CH_LM,
                CH_ESC, CH_LBRK, CH_QUEST, CH_0 + 8'd2, CH_0 + 8'd5, CH_LL,
                CH_ESC, CH_RBRK, CH_UA, CH_ESC, 8'h5C};
      send_burst();
      drain_actions();
      directed = sent;

      while (sent < directed + RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 3) == 0);
         add_random_sequence();
         send_burst();
         if (!paused && sent >= directed + RANDOM_BYTES / 2) begin
            drain_actions();
            paused = 1'b1;
         end
      end

      req_valid <= 1'b0;
      for (int k = 0; k < 20000 && pending != 0; k++)
         @(negedge clock);
      repeat (50) @(negedge clock);

      $display("Covered %0d bytes (%0d directed) and %0d checked actions,", bytes_seen,
               directed, actions_seen);
      $display("with UTF-8, CSI, OSC and escape traffic under random gaps and stalls.");
      if (pending != 0)
         $display("%0d expected actions never arrived", pending);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d actions outstanding", pending);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
src/aeup_pkg.sv
src/aeup_ctrl.sv
src/aeup_dp.sv
src/ansi_escape_utf8_parser.sv
verif/term_action_checker.sv
verif/tb.sv
